[src/sva_pkg.sv]
// ----------------------------------------------------------------------------
// sva_pkg: voice allocator shared types
// Event codes, register targets, command record and FSM states.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned VEL_W    = 7;
  localparam int unsigned PITCH_W  = 8;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned CH_OUT_W = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [RANK_W-1:0] RANK_NONE = 4'd0;
  localparam logic [RANK_W-1:0] RANK_NEXT = 4'd1;
  localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;

  localparam logic [WORD_W-1:0] MASK_RESET = 32'h8000_0000;

  // input mode codes
  localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
  localparam logic [1:0] MODE_REL_DONE = 2'd2;

  typedef enum logic [1:0] {
    OP_ON,
    OP_OFF,
    OP_REL
  } op_e;

  typedef enum logic [1:0] {
    TGT_VEL = 2'd0,
    TGT_MOD = 2'd1,
    TGT_CAR = 2'd2
  } tgt_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] carrier;
    logic [WORD_W-1:0] modulator;
    logic [VEL_W-1:0]  velocity;
  } cmd_t;

endpackage

[src/synth_voice_allocator.sv]
// ----------------------------------------------------------------------------
// synth_voice_allocator: polyphonic voice allocator
// Maps note events onto synth channels and issues channel register writes.
// ----------------------------------------------------------------------------
// Each accepted request is a note on, note off or release-done event; the
// block answers with the velocity/modulator/carrier register writes it causes,
// last_o marking the final write of a request. An intake stage decodes the
// mode (mode 3 is accepted and dropped) and hands a command to a two-entry
// queue; the channel engine behind it walks the channel table one channel per
// clock; a release-done pauses the walk at each channel it frees while that
// channel's velocity, modulator and carrier writes go out. pitch_index_i is
// accepted with the request but never reaches a register write. The user must
// write enable_mask (reset 0x8000_0000) through cfg_we_i/cfg_wdata_i only while
// no request is in flight; the block itself does not enforce this.
module synth_voice_allocator #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [sva_pkg::WORD_W-1:0]    cfg_wdata_i,
  // event requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [sva_pkg::WORD_W-1:0]    carrier_word_i,
  input  logic [sva_pkg::WORD_W-1:0]    modulator_word_i,
  input  logic [sva_pkg::PITCH_W-1:0]   pitch_index_i,
  input  logic [sva_pkg::VEL_W-1:0]     velocity_i,
  // register writes
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    target_o,
  output logic [sva_pkg::CH_OUT_W-1:0]  channel_o,
  output logic [sva_pkg::WORD_W-1:0]    data_o,
  output logic                          last_o
);

  logic [sva_pkg::WORD_W-1:0] enable_mask_q;

  logic          push_valid, push_ready;
  sva_pkg::cmd_t push_cmd;
  logic          cmd_valid, cmd_ready;
  sva_pkg::cmd_t cmd;

  // enable mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask_q <= sva_pkg::MASK_RESET;
    end else if (cfg_we_i) begin
      enable_mask_q <= cfg_wdata_i;
    end
  end

  // intake: decode and hold one command
  sva_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .carrier_word_i   (carrier_word_i),
    .modulator_word_i (modulator_word_i),
    .velocity_i       (velocity_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_cmd_o       (push_cmd)
  );

  // decoupling queue
  sva_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_cmd_i   (push_cmd),
    .rd_valid_o (cmd_valid),
    .rd_ready_i (cmd_ready),
    .rd_cmd_o   (cmd)
  );

  // channel engine with output register
  sva_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .enable_mask_i (enable_mask_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .target_o      (target_o),
    .channel_o     (channel_o),
    .data_o        (data_o),
    .last_o        (last_o)
  );

endmodule

[src/sva_front.sv]
// ----------------------------------------------------------------------------
// sva_front: event intake
// Accepts events, decodes the mode and holds one command for the queue.
// ----------------------------------------------------------------------------
module sva_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [sva_pkg::WORD_W-1:0]   carrier_word_i,
  input  logic [sva_pkg::WORD_W-1:0]   modulator_word_i,
  input  logic [sva_pkg::VEL_W-1:0]    velocity_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output sva_pkg::cmd_t                push_cmd_o
);

  logic          slot_vld_q, slot_vld_d;
  sva_pkg::cmd_t slot_q, slot_d;
  logic          take;
  logic          known;
  sva_pkg::op_e  op;

  always_comb begin
    known = 1'b1;
    op    = sva_pkg::OP_ON;
    unique case (mode_i)
      sva_pkg::MODE_NOTE_ON:  op = sva_pkg::OP_ON;
      sva_pkg::MODE_NOTE_OFF: op = sva_pkg::OP_OFF;
      sva_pkg::MODE_REL_DONE: op = sva_pkg::OP_REL;
      default:                known = 1'b0;  // unused mode: dropped
    endcase
  end

  assign in_ready_o   = !slot_vld_q || push_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign push_valid_o = slot_vld_q;
  assign push_cmd_o   = slot_q;

  always_comb begin
    slot_vld_d = slot_vld_q;
    slot_d     = slot_q;
    if (slot_vld_q && push_ready_i) begin
      slot_vld_d = 1'b0;
    end
    if (take && known) begin
      slot_vld_d         = 1'b1;
      slot_d.op          = op;
      slot_d.carrier     = carrier_word_i;
      slot_d.modulator   = modulator_word_i;
      slot_d.velocity    = velocity_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
    end else begin
      slot_vld_q <= slot_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

[src/sva_queue.sv]
// ----------------------------------------------------------------------------
// sva_queue: command queue
// Short FIFO between intake and channel engine.
// ----------------------------------------------------------------------------
module sva_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  sva_pkg::cmd_t wr_cmd_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output sva_pkg::cmd_t rd_cmd_o
);

  localparam int unsigned PTR_W = $clog2(sva_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(sva_pkg::QUEUE_DEPTH + 1);

  sva_pkg::cmd_t    mem_q [sva_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CNT_W'(sva_pkg::QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(sva_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(sva_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

[src/sva_back.sv]
// ----------------------------------------------------------------------------
// sva_back: channel engine
// Scans one table entry per cycle, pausing at freed channels; issues writes.
// ----------------------------------------------------------------------------
module sva_back #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [sva_pkg::WORD_W-1:0]      enable_mask_i,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  sva_pkg::cmd_t                   cmd_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      target_o,
  output logic [sva_pkg::CH_OUT_W-1:0]    channel_o,
  output logic [sva_pkg::WORD_W-1:0]      data_o,
  output logic                            last_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);
  localparam int unsigned SUM_W = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

  // channel table
  logic [sva_pkg::WORD_W-1:0] note_q [CHANNELS];
  logic [CHANNELS-1:0]        free_q;
  logic [sva_pkg::RANK_W-1:0] rank_q [CHANNELS];

  sva_pkg::back_state_e state_q, state_d;
  sva_pkg::cmd_t        cmd_q, cmd_d;
  sva_pkg::tgt_e        tgt_q, tgt_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     hit_q, hit_d;
  logic [IDX_W-1:0]     fre_q, fre_d;
  logic [IDX_W-1:0]     ch_q, ch_d;
  logic                 hit_vld_q, hit_vld_d;
  logic                 hit_nz_q, hit_nz_d;
  logic                 fre_vld_q, fre_vld_d;
  logic                 last_q, last_d;
  logic [CNT_W-1:0]     pend_q, pend_d;
  logic [CHANNELS-1:0]  snap_q, snap_d;

  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  out_target_q, out_target_d;
  logic [sva_pkg::CH_OUT_W-1:0] out_channel_q, out_channel_d;
  logic [sva_pkg::WORD_W-1:0]  out_data_q, out_data_d;
  logic                        out_last_q, out_last_d;

  // table write controls
  logic                        note_we, free_we, rank_we;
  logic [IDX_W-1:0]            note_wa, free_wa, rank_wa;
  logic [sva_pkg::WORD_W-1:0]  note_wd;
  logic                        free_wd;
  logic [sva_pkg::RANK_W-1:0]  rank_wd;

  logic [sva_pkg::WORD_W-1:0]  cur_note;
  logic [sva_pkg::RANK_W-1:0]  cur_rank;
  logic                        cur_free;
  logic                        scan_last;
  logic                        any_above;
  logic                        slot_free;
  logic                        emit_ok;
  logic [SUM_W-1:0]            rank_sum;
  logic [sva_pkg::RANK_W-1:0]  off_rank;
  logic [sva_pkg::WORD_W-1:0]  vel_word;
  logic [sva_pkg::WORD_W-1:0]  wr_data;
  logic [CHANNELS-1:0]         rank_one;

  assign cur_note  = note_q[idx_q];
  assign cur_rank  = rank_q[idx_q];
  assign cur_free  = free_q[idx_q];
  assign scan_last = (idx_q == IDX_W'(CHANNELS - 1));
  assign slot_free = !out_valid_q || out_ready_i;
  assign rank_sum  = SUM_W'(pend_q) + SUM_W'(1);
  assign off_rank  = (rank_sum > SUM_W'(sva_pkg::RANK_MAX)) ? sva_pkg::RANK_MAX
                                                            : rank_sum[sva_pkg::RANK_W-1:0];
  assign vel_word  = {1'b0, cmd_q.velocity, 10'b0, cmd_q.velocity, 7'b0};

  always_comb begin
    for (int j = 0; j < CHANNELS; j++) begin
      rank_one[j] = (rank_q[j] == sva_pkg::RANK_NEXT);
    end
  end

  // later channels that also finish release in this pass
  always_comb begin
    any_above = 1'b0;
    for (int j = 0; j < CHANNELS; j++) begin
      if (snap_q[j] && (j > int'(idx_q))) begin
        any_above = 1'b1;
      end
    end
  end

  always_comb begin
    emit_ok = 1'b0;
    unique case (cmd_q.op)
      sva_pkg::OP_ON:  emit_ok = (!hit_vld_q && fre_vld_q) || (hit_vld_q && hit_nz_q);
      sva_pkg::OP_OFF: emit_ok = hit_vld_q;
      default:         emit_ok = 1'b0;
    endcase
  end

  always_comb begin
    wr_data = '0;
    case (tgt_q)
      sva_pkg::TGT_VEL: wr_data = (cmd_q.op == sva_pkg::OP_ON) ? vel_word : '0;
      sva_pkg::TGT_MOD: wr_data = (cmd_q.op == sva_pkg::OP_ON) ? cmd_q.modulator : '0;
      sva_pkg::TGT_CAR: begin
        case (cmd_q.op)
          sva_pkg::OP_ON:  wr_data = cmd_q.carrier | enable_mask_i;
          sva_pkg::OP_OFF: wr_data = cmd_q.carrier & ~enable_mask_i;
          default:         wr_data = '0;
        endcase
      end
      default: wr_data = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sva_pkg::ST_IDLE: begin
        if (cmd_valid_i) state_d = sva_pkg::ST_SCAN;
      end
      sva_pkg::ST_SCAN: begin
        if (cmd_q.op == sva_pkg::OP_REL) begin
          if (cur_rank == sva_pkg::RANK_NEXT) state_d = sva_pkg::ST_EMIT;
          else if (scan_last)                 state_d = sva_pkg::ST_IDLE;
        end else if (scan_last) begin
          state_d = sva_pkg::ST_DECIDE;
        end
      end
      sva_pkg::ST_DECIDE: begin
        state_d = emit_ok ? sva_pkg::ST_EMIT : sva_pkg::ST_IDLE;
      end
      sva_pkg::ST_EMIT: begin
        if (slot_free && tgt_q == sva_pkg::TGT_CAR) begin
          if (cmd_q.op == sva_pkg::OP_REL && !scan_last) state_d = sva_pkg::ST_SCAN;
          else                                           state_d = sva_pkg::ST_IDLE;
        end
      end
      default: state_d = sva_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d     = cmd_q;
    tgt_d     = tgt_q;
    idx_d     = idx_q;
    hit_d     = hit_q;
    fre_d     = fre_q;
    ch_d      = ch_q;
    hit_vld_d = hit_vld_q;
    hit_nz_d  = hit_nz_q;
    fre_vld_d = fre_vld_q;
    last_d    = last_q;
    pend_d    = pend_q;
    snap_d    = snap_q;
    cmd_ready_o = 1'b0;
    note_we = 1'b0; note_wa = idx_q; note_wd = '0;
    free_we = 1'b0; free_wa = idx_q; free_wd = 1'b1;
    rank_we = 1'b0; rank_wa = idx_q; rank_wd = sva_pkg::RANK_NONE;

    out_valid_d   = out_valid_q && !out_ready_i;
    out_target_d  = out_target_q;
    out_channel_d = out_channel_q;
    out_data_d    = out_data_q;
    out_last_d    = out_last_q;

    unique case (state_q)
      sva_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d     = cmd_i;
          idx_d     = '0;
          hit_vld_d = 1'b0;
          hit_nz_d  = 1'b0;
          fre_vld_d = 1'b0;
          pend_d    = '0;
          snap_d    = rank_one;
        end
      end
      sva_pkg::ST_SCAN: begin
        if (cmd_q.op == sva_pkg::OP_REL) begin
          if (cur_rank == sva_pkg::RANK_NEXT) begin
            rank_we = 1'b1;
            note_we = 1'b1;
            free_we = 1'b1;
            ch_d    = idx_q;
            tgt_d   = sva_pkg::TGT_VEL;
            last_d  = !any_above;
          end else begin
            if (cur_rank > sva_pkg::RANK_NEXT) begin
              rank_we = 1'b1;
              rank_wd = cur_rank - 1'b1;
            end
            if (!scan_last) idx_d = idx_q + 1'b1;
          end
        end else begin
          if (cur_note == cmd_q.carrier) begin
            hit_vld_d = 1'b1;
            hit_d     = idx_q;
            hit_nz_d  = (cur_rank != sva_pkg::RANK_NONE);
          end
          if (cur_free && !fre_vld_q) begin
            fre_vld_d = 1'b1;
            fre_d     = idx_q;
          end
          if (cur_rank != sva_pkg::RANK_NONE) pend_d = pend_q + 1'b1;
          if (!scan_last) idx_d = idx_q + 1'b1;
        end
      end
      sva_pkg::ST_DECIDE: begin
        last_d = 1'b1;
        if (cmd_q.op == sva_pkg::OP_ON) begin
          if (!hit_vld_q) begin
            // new note: lowest free channel takes it
            ch_d    = fre_q;
            tgt_d   = sva_pkg::TGT_VEL;
            note_we = fre_vld_q;
            note_wa = fre_q;
            note_wd = cmd_q.carrier;
            free_we = fre_vld_q;
            free_wa = fre_q;
            free_wd = 1'b0;
          end else begin
            // held note: cancel a pending release
            ch_d    = hit_q;
            tgt_d   = sva_pkg::TGT_CAR;
            rank_we = hit_nz_q;
            rank_wa = hit_q;
            rank_wd = sva_pkg::RANK_NONE;
          end
        end else begin
          ch_d    = hit_q;
          tgt_d   = sva_pkg::TGT_CAR;
          rank_we = hit_vld_q;
          rank_wa = hit_q;
          rank_wd = off_rank;
        end
      end
      sva_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_target_d  = 2'(tgt_q);
          out_channel_d = sva_pkg::CH_OUT_W'(ch_q);
          out_data_d    = wr_data;
          out_last_d    = (tgt_q == sva_pkg::TGT_CAR) && last_q;
          unique case (tgt_q)
            sva_pkg::TGT_VEL: tgt_d = sva_pkg::TGT_MOD;
            sva_pkg::TGT_MOD: tgt_d = sva_pkg::TGT_CAR;
            default: begin
              if (!scan_last) idx_d = idx_q + 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sva_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      free_q      <= '1;
      for (int j = 0; j < CHANNELS; j++) begin
        note_q[j] <= '0;
        rank_q[j] <= sva_pkg::RANK_NONE;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (note_we) note_q[note_wa] <= note_wd;
      if (free_we) free_q[free_wa] <= free_wd;
      if (rank_we) rank_q[rank_wa] <= rank_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    tgt_q         <= tgt_d;
    idx_q         <= idx_d;
    hit_q         <= hit_d;
    fre_q         <= fre_d;
    ch_q          <= ch_d;
    hit_vld_q     <= hit_vld_d;
    hit_nz_q      <= hit_nz_d;
    fre_vld_q     <= fre_vld_d;
    last_q        <= last_d;
    pend_q        <= pend_d;
    snap_q        <= snap_d;
    out_target_q  <= out_target_d;
    out_channel_q <= out_channel_d;
    out_data_q    <= out_data_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign target_o    = out_target_q;
  assign channel_o   = out_channel_q;
  assign data_o      = out_data_q;
  assign last_o      = out_last_q;

endmodule

[tb/sv/synth_voice_allocator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// synth_voice_allocator_checker: register write scoreboard
// Tracks the channel table from observed requests and compares every write.
// ----------------------------------------------------------------------------
module synth_voice_allocator_checker #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sva_pkg::WORD_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    mode_i,
  input  logic [sva_pkg::WORD_W-1:0]    carrier_word_i,
  input  logic [sva_pkg::WORD_W-1:0]    modulator_word_i,
  input  logic [sva_pkg::PITCH_W-1:0]   pitch_index_i,
  input  logic [sva_pkg::VEL_W-1:0]     velocity_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [1:0]                    target_i,
  input  logic [sva_pkg::CH_OUT_W-1:0]  channel_i,
  input  logic [sva_pkg::WORD_W-1:0]    data_i,
  input  logic                          last_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   writes_seen_o,
  output int unsigned                   requests_seen_o
);

  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    sva_pkg::tgt_e                target;
    logic [sva_pkg::CH_OUT_W-1:0] channel;
    logic [sva_pkg::WORD_W-1:0]   data;
    logic                         last;
  } reg_write_t;

  // shadow channel table
  logic [sva_pkg::WORD_W-1:0]  enable_mask;
  logic [sva_pkg::WORD_W-1:0]  note_word  [CHANNELS];
  logic [sva_pkg::WORD_W-1:0]  mod_shadow [CHANNELS];
  logic [sva_pkg::PITCH_W-1:0] pitch_tag  [CHANNELS];
  logic                        chan_free  [CHANNELS];
  logic                        chan_on    [CHANNELS];
  logic [sva_pkg::RANK_W-1:0]  rank       [CHANNELS];

  reg_write_t expected_writes [$];

  function automatic reg_write_t make_write(sva_pkg::tgt_e t, int unsigned ch,
                                            logic [sva_pkg::WORD_W-1:0] d);
    reg_write_t w;
    w.target  = t;
    w.channel = sva_pkg::CH_OUT_W'(ch);
    w.data    = d;
    w.last    = 1'b0;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Apply one event to the shadow table, queue the writes it causes.
  task automatic predict_voice_writes(input logic [1:0] mode,
                                      input logic [sva_pkg::WORD_W-1:0] car,
                                      input logic [sva_pkg::WORD_W-1:0] modw,
                                      input logic [sva_pkg::PITCH_W-1:0] idx,
                                      input logic [sva_pkg::VEL_W-1:0] vel);
    reg_write_t  batch [$];
    reg_write_t  w;
    int          hit;
    int unsigned busy;
    bit          placed;
    hit    = -1;
    busy   = 0;
    placed = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (note_word[i] == car) hit = i;
      if (rank[i] != sva_pkg::RANK_NONE) busy++;
    end
    case (mode)
      sva_pkg::MODE_NOTE_ON: begin
        if (hit < 0) begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (!placed && chan_free[i]) begin
              placed        = 1'b1;
              note_word[i]  = car;
              mod_shadow[i] = modw;
              pitch_tag[i]  = idx;
              batch.push_back(make_write(sva_pkg::TGT_VEL, i,
                              (sva_pkg::WORD_W'(vel) << 24) |
                              (sva_pkg::WORD_W'(vel) << 7)));
              batch.push_back(make_write(sva_pkg::TGT_MOD, i, modw));
              batch.push_back(make_write(sva_pkg::TGT_CAR, i, car | enable_mask));
              chan_free[i] = 1'b0;
              chan_on[i]   = 1'b1;
            end
          end
        end else if (rank[hit] != sva_pkg::RANK_NONE) begin
          // re-trigger during release
          rank[hit]    = sva_pkg::RANK_NONE;
          batch.push_back(make_write(sva_pkg::TGT_CAR, hit, car | enable_mask));
          chan_on[hit] = 1'b1;
        end
      end
      sva_pkg::MODE_NOTE_OFF: begin
        if (hit >= 0) begin
          if (busy + 1 > sva_pkg::RANK_MAX) rank[hit] = sva_pkg::RANK_MAX;
          else rank[hit] = sva_pkg::RANK_W'(busy + 1);
          batch.push_back(make_write(sva_pkg::TGT_CAR, hit, car & ~enable_mask));
          chan_on[hit] = 1'b0;
        end
      end
      sva_pkg::MODE_REL_DONE: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (rank[i] == sva_pkg::RANK_NEXT) begin
            rank[i] = sva_pkg::RANK_NONE;
            batch.push_back(make_write(sva_pkg::TGT_VEL, i, '0));
            batch.push_back(make_write(sva_pkg::TGT_MOD, i, '0));
            batch.push_back(make_write(sva_pkg::TGT_CAR, i, '0));
            note_word[i]  = '0;
            mod_shadow[i] = '0;
            pitch_tag[i]  = '1;
            chan_free[i]  = 1'b1;
          end else if (rank[i] > sva_pkg::RANK_NEXT) begin
            rank[i] = rank[i] - 1'b1;
          end
        end
      end
      default: ;
    endcase
    foreach (batch[k]) begin
      w      = batch[k];
      w.last = (k == batch.size() - 1);
      expected_writes.push_back(w);
    end
  endtask

  task automatic check_write();
    reg_write_t exp_w;
    writes_seen_o++;
    if (expected_writes.size() == 0) begin
      report_mismatch($sformatf("unexpected write tgt=%0d ch=%0d data=%h last=%0b",
                                target_i, channel_i, data_i, last_i));
    end else begin
      exp_w = expected_writes.pop_front();
      if (target_i !== exp_w.target)
        report_mismatch($sformatf("target got %0d exp %0d", target_i, exp_w.target));
      if (channel_i !== exp_w.channel)
        report_mismatch($sformatf("channel got %0d exp %0d", channel_i, exp_w.channel));
      if (data_i !== exp_w.data)
        report_mismatch($sformatf("data got %h exp %h (ch %0d)", data_i, exp_w.data,
                                  exp_w.channel));
      if (last_i !== exp_w.last)
        report_mismatch($sformatf("last got %0b exp %0b", last_i, exp_w.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask = sva_pkg::MASK_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        note_word[i]  = '0;
        mod_shadow[i] = '0;
        pitch_tag[i]  = '1;
        chan_free[i]  = 1'b1;
        chan_on[i]    = 1'b0;
        rank[i]       = sva_pkg::RANK_NONE;
      end
      expected_writes.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      writes_seen_o   = 0;
      requests_seen_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_write();
      if (in_valid_i && in_ready_i) begin
        requests_seen_o++;
        predict_voice_writes(mode_i, carrier_word_i, modulator_word_i, pitch_index_i,
                             velocity_i);
      end
      if (cfg_we_i) enable_mask = cfg_wdata_i;
      pending_o = expected_writes.size();
    end
  end

endmodule

[tb/sv/tb_synth_voice_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_synth_voice_allocator: voice allocator testbench
// Directed note on/off/release sequences, then random event traffic under
// several enable_mask settings, with random idling on both handshakes. A
// separate checker predicts and compares every register write.
// ----------------------------------------------------------------------------
module tb_synth_voice_allocator;

  localparam int unsigned CHANNELS      = 8;
  localparam int unsigned RANDOM_EVENTS = 196;
  localparam int unsigned PHASES        = 4;
  localparam int unsigned MAX_GAP       = 12;
  // A request that writes nothing can still be in the engine when the last
  // expected write has come out, with two queue entries and the intake behind
  // it, each needing a full scan. DRAIN_CYCLES covers that with room to spare.
  localparam int unsigned DRAIN_CYCLES  = 80;
  // Worst case per request: 24 writes, each behind a write-side stall of up to
  // MAX_GAP, plus a full scan and a request-side gap of up to MAX_GAP. The
  // limit covers that for ~220 requests several times over.
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned POOL_SIZE     = 10;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [sva_pkg::WORD_W-1:0]    cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [1:0]                    mode_i;
  logic [sva_pkg::WORD_W-1:0]    carrier_word_i;
  logic [sva_pkg::WORD_W-1:0]    modulator_word_i;
  logic [sva_pkg::PITCH_W-1:0]   pitch_index_i;
  logic [sva_pkg::VEL_W-1:0]     velocity_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [1:0]                    target_o;
  logic [sva_pkg::CH_OUT_W-1:0]  channel_o;
  logic [sva_pkg::WORD_W-1:0]    data_o;
  logic                          last_o;

  int unsigned fail_count;
  int unsigned writes_pending;
  int unsigned writes_seen;
  int unsigned requests_seen;
  int unsigned cycle_count;
  int unsigned mask_writes;

  // Cleared for stretches where both sides run back to back.
  bit idle_en;

  // Carrier words the random traffic keeps hitting, so notes actually match.
  logic [sva_pkg::WORD_W-1:0] note_pool [POOL_SIZE];

  synth_voice_allocator #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .carrier_word_i   (carrier_word_i),
    .modulator_word_i (modulator_word_i),
    .pitch_index_i    (pitch_index_i),
    .velocity_i       (velocity_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .target_o         (target_o),
    .channel_o        (channel_o),
    .data_o           (data_o),
    .last_o           (last_o)
  );

  synth_voice_allocator_checker #(
    .CHANNELS(CHANNELS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .mode_i           (mode_i),
    .carrier_word_i   (carrier_word_i),
    .modulator_word_i (modulator_word_i),
    .pitch_index_i    (pitch_index_i),
    .velocity_i       (velocity_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .target_i         (target_o),
    .channel_i        (channel_o),
    .data_i           (data_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .pending_o        (writes_pending),
    .writes_seen_o    (writes_seen),
    .requests_seen_o  (requests_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL synth_voice_allocator");
      $finish;
    end
  end

  // Write side: before each write, ready drops for a random stall of up to
  // MAX_GAP, then ready stays high until a write is taken. Changes land on the
  // falling edge; the handshake is sampled on the rising edge.
  initial begin : write_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Send one event request. Called on a falling edge, returns on the falling
  // edge after acceptance. With no gap, valid simply stays high into the
  // next request so it is never dropped and raised in one step.
  task automatic send_event(input logic [1:0] mode,
                            input logic [sva_pkg::WORD_W-1:0] car,
                            input logic [sva_pkg::WORD_W-1:0] modw,
                            input logic [sva_pkg::PITCH_W-1:0] idx,
                            input logic [sva_pkg::VEL_W-1:0] vel);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i           <= mode;
    carrier_word_i   <= car;
    modulator_word_i <= modw;
    pitch_index_i    <= idx;
    velocity_i       <= vel;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid, let every predicted write come out, then let any request
  // that writes nothing clear the engine.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (writes_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_enable_mask(input logic [sva_pkg::WORD_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mask_writes++;
  endtask

  // Mostly note on/off on pooled carriers so channels fill, match, release
  // and get reused; a few fully random carriers, carrier zero and the
  // unused mode as noise.
  task automatic random_event();
    int unsigned pick;
    logic [1:0]  mode;
    logic [sva_pkg::WORD_W-1:0] car;
    pick = $urandom_range(0, 99);
    if (pick < 40)      mode = sva_pkg::MODE_NOTE_ON;
    else if (pick < 75) mode = sva_pkg::MODE_NOTE_OFF;
    else if (pick < 95) mode = sva_pkg::MODE_REL_DONE;
    else                mode = MODE_UNUSED;
    pick = $urandom_range(0, 19);
    if (pick == 0)      car = $urandom;
    else if (pick == 1) car = '0;
    else                car = note_pool[$urandom_range(0, POOL_SIZE - 1)];
    send_event(mode, car, $urandom, sva_pkg::PITCH_W'($urandom),
               sva_pkg::VEL_W'($urandom));
  endtask

  // Directed opener, under the reset value of enable_mask.
  task automatic directed_events();
    // unused mode: accepted, no writes
    send_event(MODE_UNUSED, $urandom, $urandom, sva_pkg::PITCH_W'($urandom),
               sva_pkg::VEL_W'($urandom));
    // carrier zero matches every cleared channel: note on does nothing,
    // note off ranks the top channel, release-done clears it again
    send_event(sva_pkg::MODE_NOTE_ON, '0, $urandom, 8'd0, 7'd64);
    send_event(sva_pkg::MODE_NOTE_OFF, '0, '0, 8'd0, 7'd0);
    send_event(sva_pkg::MODE_REL_DONE, '0, '0, 8'd0, 7'd0);
    // note off for a note nobody holds
    send_event(sva_pkg::MODE_NOTE_OFF, 32'h5A5A_5A5A, '0, 8'd0, 7'd0);
    // fill every channel; field extremes on the first two
    for (int i = 0; i < CHANNELS; i++) begin
      send_event(sva_pkg::MODE_NOTE_ON, note_pool[i],
                 (i == 0) ? '1 : (i == 1) ? '0 : sva_pkg::WORD_W'($urandom),
                 (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : sva_pkg::PITCH_W'($urandom),
                 (i == 0) ? 7'h7F : (i == 1) ? 7'h00 : sva_pkg::VEL_W'($urandom));
    end
    // all channels busy: a new note is dropped
    send_event(sva_pkg::MODE_NOTE_ON, 32'h7F00_0001, $urandom, 8'd1, 7'd1);
    // note already held and sounding: nothing
    send_event(sva_pkg::MODE_NOTE_ON, note_pool[3], $urandom, 8'd3, 7'd3);
    // release cancelled by a new note on
    send_event(sva_pkg::MODE_NOTE_OFF, note_pool[1], '0, 8'd0, 7'd0);
    send_event(sva_pkg::MODE_NOTE_ON, note_pool[1], $urandom, 8'd1, 7'd100);
    // second note off on a pending channel counts itself; leaves ch0 and
    // ch2 sharing a rank, so the last release-done frees both at once
    send_event(sva_pkg::MODE_NOTE_OFF, note_pool[0], '0, 8'd0, 7'd0);
    send_event(sva_pkg::MODE_NOTE_OFF, note_pool[1], '0, 8'd0, 7'd0);
    send_event(sva_pkg::MODE_NOTE_OFF, note_pool[0], '0, 8'd0, 7'd0);
    send_event(sva_pkg::MODE_NOTE_OFF, note_pool[2], '0, 8'd0, 7'd0);
    repeat (3) send_event(sva_pkg::MODE_REL_DONE, '0, '0, 8'd0, 7'd0);
  endtask

  initial begin : stimulus
    logic [sva_pkg::WORD_W-1:0] mask_plan [PHASES];
    // every input known from time zero; reset held low at the start
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    mode_i           = sva_pkg::MODE_NOTE_ON;
    carrier_word_i   = '0;
    modulator_word_i = '0;
    pitch_index_i    = '0;
    velocity_i       = '0;
    idle_en          = 1'b1;
    mask_writes      = 0;

    // pool: an all-ones carrier, then distinct nonzero words tagged by the
    // top byte so they never collide with the directed drop/miss words
    note_pool[0] = '1;
    for (int i = 1; i < POOL_SIZE; i++) note_pool[i] = {8'(i), 24'($urandom)};

    mask_plan[0] = 32'h0000_0000;
    mask_plan[1] = 32'hFFFF_FFFF;
    mask_plan[2] = $urandom;
    mask_plan[3] = sva_pkg::MASK_RESET;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_events();

    for (int p = 0; p < PHASES; p++) begin
      write_enable_mask(mask_plan[p]);
      // the all-ones phase runs both handshakes flat out
      idle_en = (p != 1);
      repeat (RANDOM_EVENTS / PHASES) random_event();
    end

    wait_idle();
    $display("Covered %0d event requests (directed and random) over %0d enable_mask writes,",
             requests_seen, mask_writes);
    $display("with %0d register writes checked against the channel table.", writes_seen);
    if (fail_count == 0 && writes_pending == 0) begin
      $display("PASS synth_voice_allocator");
    end else begin
      $display("FAIL synth_voice_allocator");
    end
    $finish;
  end

endmodule
